/* rtl/itc_pkg.sv */
// Package for the integer-to-text radix converter: widths, format codes,
// controller/datapath command and status types, and ASCII helpers.
// Depends on nothing; every other file imports it.
package itc_pkg;

   localparam int VALUE_BITS = 32;
   localparam int CMD_BITS   = 3;
   localparam int CHAR_BITS  = 8;
   localparam int DIGIT_BITS = 4;

   // The longest text is the binary magnitude of the most negative value.
   localparam int MAX_DIGITS = VALUE_BITS;
   localparam int COUNT_BITS = $clog2(MAX_DIGITS + 1);
   localparam int STACK_BITS = MAX_DIGITS * DIGIT_BITS;

   // Division by ten is a multiplication by a rounded-up reciprocal.
   localparam int CONST_BITS = VALUE_BITS + 8;
   localparam int DEC_SHIFT  = VALUE_BITS + 3;
   localparam logic [VALUE_BITS-1:0] DEC_RECIP =
      VALUE_BITS'(((CONST_BITS'(1) << DEC_SHIFT) + CONST_BITS'(9)) / CONST_BITS'(10));

   typedef enum logic [CMD_BITS-1:0] {
      CMD_UDEC      = 3'd0,
      CMD_SDEC      = 3'd1,
      CMD_BIN       = 3'd2,
      CMD_OCT       = 3'd3,
      CMD_HEX_LOWER = 3'd4,
      CMD_HEX_UPPER = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      OUT_DIGIT,
      OUT_MINUS,
      OUT_BAD
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic        pop;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic in_bad;
      logic step_zero;
      logic last_digit;
      logic neg;
   } dp_status_type;

   localparam logic [CHAR_BITS-1:0] CHAR_NONE    = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 4'd10;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                                      input logic upper);
      logic [CHAR_BITS-1:0] ext;
      ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + ext;
      end else begin
         return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + ext - CHAR_BITS'(DIGIT_TEN);
      end
   endfunction

endpackage

/* rtl/itc_if.sv */
// Handshake channels of the integer-to-text radix converter.
// Depends on itc_pkg for field widths.
interface itc_req_if import itc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [CMD_BITS-1:0]   cmd;

   modport source (output valid, output value, output cmd, input ready);
   modport sink   (input valid, input value, input cmd, output ready);
endinterface

interface itc_rsp_if import itc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] character;
   logic                 last;
   logic                 bad_format;

   modport source (output valid, output character, output last, output bad_format,
                   input ready);
   modport sink   (input valid, input character, input last, input bad_format,
                   output ready);
endinterface

/* rtl/itc_dpath.sv */
// Datapath: magnitude register, one-digit-per-cycle radix step, digit stack
// and character formatting. Depends on itc_pkg.
module itc_dpath import itc_pkg::*; (
   input  logic                  clock,
   input  dp_cmd_type            cmd,
   input  logic [VALUE_BITS-1:0] in_value,
   input  logic [CMD_BITS-1:0]   in_cmd,
   output dp_status_type         status,
   output logic [CHAR_BITS-1:0]  out_char,
   output logic                  out_last,
   output logic                  out_bad
);

   logic [VALUE_BITS-1:0] mag_ff,   mag_in;
   logic [CMD_BITS-1:0]   cmd_ff,   cmd_in;
   logic                  neg_ff,   neg_in;
   logic [STACK_BITS-1:0] stack_ff, stack_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [2*VALUE_BITS-1:0] prod;
   logic [VALUE_BITS-1:0]   dec_q;
   logic [VALUE_BITS-1:0]   dec_r;
   logic [VALUE_BITS-1:0]   quot;
   logic [DIGIT_BITS-1:0]   digit;
   logic                    in_signed;
   logic                    upper;

   always_comb begin
      prod  = (2*VALUE_BITS)'(mag_ff) * (2*VALUE_BITS)'(DEC_RECIP);
      dec_q = VALUE_BITS'(prod >> DEC_SHIFT);
      dec_r = mag_ff - ((dec_q << 3) + (dec_q << 1));
      case (cmd_ff) inside
         CMD_UDEC, CMD_SDEC: begin
            quot  = dec_q;
            digit = dec_r[DIGIT_BITS-1:0];
         end
         CMD_BIN: begin
            quot  = mag_ff >> 1;
            digit = {3'b000, mag_ff[0]};
         end
         CMD_OCT: begin
            quot  = mag_ff >> 3;
            digit = {1'b0, mag_ff[2:0]};
         end
         default: begin
            quot  = mag_ff >> 4;
            digit = mag_ff[3:0];
         end
      endcase
   end

   assign in_signed = (in_cmd == CMD_SDEC) || (in_cmd == CMD_BIN);
   assign upper     = (cmd_ff == CMD_HEX_UPPER);

   assign status.in_bad     = (in_cmd > CMD_HEX_UPPER);
   assign status.step_zero  = (quot == '0);
   assign status.last_digit = (count_ff == COUNT_BITS'(1));
   assign status.neg        = neg_ff;

   always_comb begin
      mag_in   = mag_ff;
      cmd_in   = cmd_ff;
      neg_in   = neg_ff;
      stack_in = stack_ff;
      count_in = count_ff;
      if (cmd.load) begin
         cmd_in   = in_cmd;
         count_in = '0;
         if (in_signed && in_value[VALUE_BITS-1]) begin
            mag_in = ~in_value + VALUE_BITS'(1);
            neg_in = 1'b1;
         end else begin
            mag_in = in_value;
            neg_in = 1'b0;
         end
      end else if (cmd.step) begin
         mag_in   = quot;
         stack_in = {stack_ff[STACK_BITS-DIGIT_BITS-1:0], digit};
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.pop) begin
         stack_in = {{DIGIT_BITS{1'b0}}, stack_ff[STACK_BITS-1:DIGIT_BITS]};
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      cmd_ff   <= cmd_in;
      neg_ff   <= neg_in;
      stack_ff <= stack_in;
      count_ff <= count_in;
   end

   always_comb begin
      unique case (cmd.out_sel)
         OUT_DIGIT: begin
            out_char = digit_char(stack_ff[DIGIT_BITS-1:0], upper);
            out_last = status.last_digit;
            out_bad  = 1'b0;
         end
         OUT_MINUS: begin
            out_char = CHAR_MINUS;
            out_last = 1'b0;
            out_bad  = 1'b0;
         end
         default: begin
            out_char = CHAR_NONE;
            out_last = 1'b1;
            out_bad  = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/itc_ctrl.sv */
// Controller: sequences load, digit extraction and character beats.
// Depends on itc_pkg for the command and status types.
module itc_ctrl import itc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   output logic          out_valid,
   input  logic          out_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_MINUS,
      ST_EMIT,
      ST_BAD
   } state_type;

   state_type state_ff;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_MINUS) || (state_ff == ST_EMIT) ||
                      (state_ff == ST_BAD);

   always_comb begin
      cmd.load = in_valid && in_ready;
      cmd.step = (state_ff == ST_STEP);
      cmd.pop  = (state_ff == ST_EMIT) && out_ready;
      unique case (state_ff)
         ST_MINUS: cmd.out_sel = OUT_MINUS;
         ST_BAD:   cmd.out_sel = OUT_BAD;
         default:  cmd.out_sel = OUT_DIGIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  state_ff <= status.in_bad ? ST_BAD : ST_STEP;
               end
            end
            ST_STEP: begin
               if (status.step_zero) begin
                  state_ff <= status.neg ? ST_MINUS : ST_EMIT;
               end
            end
            ST_MINUS: begin
               if (out_ready) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_ready && status.last_digit) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_BAD: begin
               if (out_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* rtl/integer_to_text_radix_core.sv */
// Top level of the integer-to-text radix converter: controller plus datapath.
// Depends on itc_pkg, itc_if, itc_ctrl and itc_dpath.
//
//   Channel   Direction  Beat contents
//   req_bus   in         value (32 bits), cmd (3 bits)
//   rsp_bus   out        character (8 bits), last, bad_format
//
// Each digit comes from the single radix step unit (shift or multiply by the
// reciprocal of ten), one digit per cycle into a digit stack; the digits are
// then emitted from the stack, after a leading minus for a negative value.
// Reset is synchronous and returns the controller to idle. A stalled response
// beat holds until taken; no new request is accepted until the final beat of
// the current item has gone.
module integer_to_text_radix_core import itc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   itc_req_if.sink  req_bus,
   itc_rsp_if.source rsp_bus
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   itc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   itc_dpath u_dpath (
      .clock    (clock),
      .cmd      (dp_cmd),
      .in_value (req_bus.value),
      .in_cmd   (req_bus.cmd),
      .status   (dp_status),
      .out_char (rsp_bus.character),
      .out_last (rsp_bus.last),
      .out_bad  (rsp_bus.bad_format)
   );

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request accepted while a response beat is pending");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.bad_format |->
         rsp_bus.last && (rsp_bus.character == CHAR_NONE))
      else $error("bad format beat is not a single empty final beat");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && rsp_bus.last |=> req_bus.ready)
      else $error("block not ready after the final beat");

   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && !dp_status.in_bad |=> !rsp_bus.valid)
      else $error("response beat appeared directly after accept");
`endif

endmodule

/* sim/tb_integer_to_text_radix_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_text_radix_core: random and directed conversions,
// checked character by character against a built-in predictor of the ASCII text.
// Depends on itc_pkg, the itc_req_if/itc_rsp_if channels and the core itself.
module tb_integer_to_text_radix_core;
   import itc_pkg::*;

   localparam int                  CYCLE_LIMIT    = 1_000_000;
   localparam int                  ITEMS_PER_LOAD = 75;
   localparam int                  SETTLE_CYCLES  = 80;
   localparam logic [CMD_BITS-1:0] CMD_BAD_SIX    = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_BAD_SEVEN  = 3'd7;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic [CMD_BITS-1:0]   cmd;
   } convert_request_type;

   typedef struct {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
      logic                 bad_format;
   } text_char_type;

   logic clock;
   logic reset;

   itc_req_if req_bus ();
   itc_rsp_if rsp_bus ();

   integer_to_text_radix_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   convert_request_type pending_requests[$];
   text_char_type       expected_text[$];
   int                  send_idle_pct;
   int                  recv_stall_pct;
   int                  mismatch_count;
   int                  cycle_count;
   bit                  request_taken;

   always #5 clock = ~clock;

   function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                        input logic [CMD_BITS-1:0] cmd);
      logic [VALUE_BITS-1:0] magnitude;
      logic [VALUE_BITS-1:0] radix;
      logic [VALUE_BITS-1:0] remainder;
      logic [CHAR_BITS-1:0]  alpha_base;
      logic [CHAR_BITS-1:0]  reversed[$];
      logic [CHAR_BITS-1:0]  ch;
      bit                    signed_format;
      magnitude     = value;
      signed_format = 1'b0;
      alpha_base    = CHAR_LOWER_A;
      radix         = 10;
      case (cmd)
         CMD_UDEC: radix = 10;
         CMD_SDEC: begin
            radix         = 10;
            signed_format = 1'b1;
         end
         CMD_BIN: begin
            radix         = 2;
            signed_format = 1'b1;
         end
         CMD_OCT:       radix = 8;
         CMD_HEX_LOWER: radix = 16;
         CMD_HEX_UPPER: begin
            radix      = 16;
            alpha_base = CHAR_UPPER_A;
         end
         default: begin
            expected_text.push_back('{character: CHAR_NONE, last: 1'b1, bad_format: 1'b1});
            return;
         end
      endcase
      // Negation wraps the most negative value onto itself, which read unsigned is 2^31.
      if (signed_format && value[VALUE_BITS-1]) begin
         expected_text.push_back('{character: CHAR_MINUS, last: 1'b0, bad_format: 1'b0});
         magnitude = -value;
      end
      if (magnitude == 0) begin
         reversed.push_back(CHAR_ZERO);
      end
      while (magnitude != 0) begin
         remainder = magnitude % radix;
         if (remainder < 10) begin
            reversed.push_back(CHAR_ZERO + remainder[CHAR_BITS-1:0]);
         end else begin
            reversed.push_back(alpha_base + remainder[CHAR_BITS-1:0] - CHAR_BITS'(10));
         end
         magnitude = magnitude / radix;
      end
      while (reversed.size() > 0) begin
         ch = reversed.pop_back();
         expected_text.push_back('{character: ch, last: (reversed.size() == 0),
                                   bad_format: 1'b0});
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(5))
         0: v = VALUE_BITS'($urandom_range(1000));
         1: v = -VALUE_BITS'($urandom_range(1, 1000));
         2: v = VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1);
         3: v = (VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1)) - VALUE_BITS'(1);
         4: v = ~((VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1)) - VALUE_BITS'(1));
         default: v = VALUE_BITS'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [CMD_BITS-1:0] random_cmd();
      if ($urandom_range(15) == 0) begin
         return ($urandom_range(1) == 0) ? CMD_BAD_SIX : CMD_BAD_SEVEN;
      end
      return CMD_BITS'($urandom_range(CMD_HEX_UPPER));
   endfunction

   task automatic queue_request(input logic [VALUE_BITS-1:0] value,
                                input logic [CMD_BITS-1:0] cmd);
      convert_request_type r;
      r.value = value;
      r.cmd   = cmd;
      pending_requests.push_back(r);
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_bus.valid || expected_text.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(negedge clock) begin : drive_requests
      convert_request_type r;
      if (!req_bus.valid || request_taken) begin
         request_taken = 1'b0;
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            r = pending_requests.pop_front();
            req_bus.value <= r.value;
            req_bus.cmd   <= r.cmd;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_text
      text_char_type want;
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_text(req_bus.value, req_bus.cmd);
         request_taken = 1'b1;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_text.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
               $display("Unexpected beat: character %h last %b bad_format %b",
                        rsp_bus.character, rsp_bus.last, rsp_bus.bad_format);
            end
         end else begin
            want = expected_text.pop_front();
            if (rsp_bus.character !== want.character || rsp_bus.last !== want.last ||
                rsp_bus.bad_format !== want.bad_format) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected %h/%b/%b, got %h/%b/%b",
                           want.character, want.last, want.bad_format,
                           rsp_bus.character, rsp_bus.last, rsp_bus.bad_format);
               end
            end
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.value  = '0;
      req_bus.cmd    = '0;
      rsp_bus.ready  = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      request_taken  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero in every format, all-ones in every format, and the signed extremes.
      for (int c = CMD_UDEC; c <= CMD_HEX_UPPER; c++) begin
         queue_request('0, CMD_BITS'(c));
         queue_request('1, CMD_BITS'(c));
      end
      queue_request(32'h8000_0000, CMD_SDEC);
      queue_request(32'h8000_0000, CMD_BIN);
      queue_request(32'h8000_0000, CMD_UDEC);
      queue_request(32'h7FFF_FFFF, CMD_SDEC);
      queue_request(32'h7FFF_FFFF, CMD_BIN);
      queue_request(32'hDEAD_BEEF, CMD_HEX_LOWER);
      queue_request(32'hDEAD_BEEF, CMD_HEX_UPPER);
      queue_request(32'h0000_0001, CMD_SDEC);
      queue_request(32'hFEDC_BA98, CMD_OCT);
      queue_request(32'h1234_5678, CMD_BAD_SIX);
      queue_request(32'hA5A5_A5A5, CMD_BAD_SEVEN);

      for (int load = 0; load < 4; load++) begin
         case (load)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 70;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 70;
            end
            default: begin
               send_idle_pct  = 11;
               recv_stall_pct = 11;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_LOAD; i++) begin
            queue_request(random_value(), random_cmd());
         end
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/itc_pkg.sv
rtl/itc_if.sv
rtl/itc_dpath.sv
rtl/itc_ctrl.sv
rtl/integer_to_text_radix_core.sv
sim/tb_integer_to_text_radix_core.sv
